// ----- sv/vb64_pkg.sv -----
// Shared types, constants and symbol functions for the base64 Vigenere cipher.
package vb64_pkg;

    localparam int KEY_MAX_DEF = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] C_PAD = 8'h3D;

    localparam logic REG_KEY_LENGTH = 1'b0;
    localparam logic REG_DECRYPT = 1'b1;

    typedef enum logic [1:0] {
        MODE_DATA    = 2'd0,
        MODE_KEY     = 2'd1,
        MODE_RESTART = 2'd2
    } t_mode;

    typedef struct packed {
        logic [5:0] idx;
        logic [5:0] key;
        logic       ok;
    } t_item;

    typedef struct packed {
        logic [QCW-1:0] count;
        logic           not_empty;
    } t_queue_status;

    function automatic logic [6:0] decode_symbol(input logic [7:0] c);
        logic       ok;
        logic [5:0] idx;
        ok  = 1'b1;
        idx = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            idx = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            idx = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            idx = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            idx = 6'd62;
        end else if (c == 8'h2F) begin
            idx = 6'd63;
        end else begin
            ok = 1'b0;
        end
        return {ok, idx};
    endfunction

    function automatic logic [7:0] encode_symbol(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26) begin
            c = 8'(idx) + 8'h41;
        end else if (idx < 6'd52) begin
            c = 8'(idx) - 8'd26 + 8'h61;
        end else if (idx < 6'd62) begin
            c = 8'(idx) - 8'd52 + 8'h30;
        end else if (idx == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ----- sv/vigenere_base64_stream_cipher.sv -----
// Top level of the base64 Vigenere stream cipher with its register port.
//
// Input channel (i_in_valid / o_in_ready) carries one item per transfer:
// a data byte, a key table write or a key position restart, chosen by i_mode.
// Output channel (o_out_valid / i_out_ready) carries one cipher or plain
// symbol for each data byte that yields one; other items give nothing.
// Registers: key_length at address 0, decrypt_mode at address 4.
// Throughput is one item per cycle while o_in_ready is high. A data byte
// passes the classification register, where the registered key table read
// runs alongside it, then the queue and then the output register, where
// it holds until the receiver takes it.
// When the receiver stalls the queue fills and o_in_ready drops once it
// holds four items less any still in flight; no item is lost.
// Reset empties the queue and output register, sets the key position to 0,
// key_length to 1 and decrypt_mode to 0. The key table keeps whatever it
// held; write every key slot in use before sending data.
module vigenere_base64_stream_cipher #(
    parameter int KEY_MAX = vb64_pkg::KEY_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic [3:0]  i_key_slot,
    input  logic [5:0]  i_key_symbol,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]              r_key_length;
    logic                    r_decrypt;
    logic                    w_cfg_wr;
    logic                    w_push;
    logic                    w_pop;
    vb64_pkg::t_item         w_front_item;
    vb64_pkg::t_item         w_head_item;
    vb64_pkg::t_queue_status w_status;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 5'd1;
            r_decrypt    <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                vb64_pkg::REG_KEY_LENGTH: r_key_length <= pwdata[4:0];
                vb64_pkg::REG_DECRYPT:    r_decrypt    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            vb64_pkg::REG_KEY_LENGTH: prdata = {27'd0, r_key_length};
            vb64_pkg::REG_DECRYPT:    prdata = {31'd0, r_decrypt};
            default:                  prdata = '0;
        endcase
    end

    vb64_front #(
        .KEY_MAX (KEY_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .i_key_slot   (i_key_slot),
        .i_key_symbol (i_key_symbol),
        .i_key_length (r_key_length),
        .i_decrypt    (r_decrypt),
        .i_status     (w_status),
        .o_push       (w_push),
        .o_item       (w_front_item)
    );

    vb64_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_status)
    );

    vb64_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_decrypt (r_decrypt),
        .i_item    (w_head_item),
        .i_status  (w_status),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_byte    (o_out_byte)
    );

endmodule

// ----- sv/vb64_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vb64_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/vb64_front.sv -----
// Front end: input transfer, byte classification, key position and key table.
module vb64_front #(
    parameter int KEY_MAX = vb64_pkg::KEY_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_mode,
    input  logic [7:0]               i_data_byte,
    input  logic [3:0]               i_key_slot,
    input  logic [5:0]               i_key_symbol,
    input  logic [4:0]               i_key_length,
    input  logic                     i_decrypt,
    input  vb64_pkg::t_queue_status  i_status,
    output logic                     o_push,
    output vb64_pkg::t_item          o_item
);

    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CW = (KW + 1 > 5) ? KW + 1 : 5;

    logic [KW-1:0] r_pos, n_pos;
    logic          r_s1_valid, n_s1_valid;
    logic [5:0]    r_s1_idx;
    logic          r_s1_ok;
    logic          w_accept;
    logic          w_sym_ok;
    logic [5:0]    w_idx;
    logic          w_is_pad;
    logic          w_we;
    logic [CW-1:0] w_len;
    logic [CW-1:0] w_next;
    logic [5:0]    w_key;

    assign o_ready  = (vb64_pkg::QCW'(i_status.count) + vb64_pkg::QCW'(r_s1_valid))
                      < vb64_pkg::QCW'(vb64_pkg::QUEUE_DEPTH);
    assign w_accept = i_valid && o_ready;
    assign {w_sym_ok, w_idx} = vb64_pkg::decode_symbol(i_data_byte);
    assign w_is_pad = (i_data_byte == vb64_pkg::C_PAD);
    assign w_we     = w_accept && (i_mode == vb64_pkg::MODE_KEY)
                      && (CW'(i_key_slot) < CW'(KEY_MAX));
    assign w_next   = CW'(r_pos) + CW'(1);

    always_comb begin
        if (i_key_length == 5'd0) begin
            w_len = CW'(1);
        end else if (CW'(i_key_length) > CW'(KEY_MAX)) begin
            w_len = CW'(KEY_MAX);
        end else begin
            w_len = CW'(i_key_length);
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_s1_valid = 1'b0;
        if (w_accept) begin
            unique case (i_mode)
                vb64_pkg::MODE_DATA: begin
                    n_pos      = (w_next >= w_len) ? '0 : w_next[KW-1:0];
                    n_s1_valid = i_decrypt || w_sym_ok || w_is_pad;
                end
                vb64_pkg::MODE_RESTART: begin
                    n_pos = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= w_idx;
        r_s1_ok  <= w_sym_ok;
    end

    vb64_ram #(
        .WIDTH (6),
        .DEPTH (KEY_MAX)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (KW'(i_key_slot)),
        .i_wdata (i_key_symbol),
        .i_raddr (r_pos),
        .o_rdata (w_key)
    );

    assign o_push     = r_s1_valid;
    assign o_item.idx = r_s1_idx;
    assign o_item.key = w_key;
    assign o_item.ok  = r_s1_ok;

endmodule

// ----- sv/vb64_queue.sv -----
// Short queue between the front end and the back end.
module vb64_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  vb64_pkg::t_item         i_item,
    input  logic                    i_pop,
    output vb64_pkg::t_item         o_item,
    output vb64_pkg::t_queue_status o_status
);

    vb64_pkg::t_item r_mem [vb64_pkg::QUEUE_DEPTH];
    logic [vb64_pkg::QPW-1:0] r_wr, r_rd;
    logic [vb64_pkg::QCW-1:0] r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + vb64_pkg::QCW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - vb64_pkg::QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + vb64_pkg::QPW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + vb64_pkg::QPW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item             = r_mem[r_rd];
    assign o_status.count     = r_count;
    assign o_status.not_empty = (r_count != '0);

endmodule

// ----- sv/vb64_back.sv -----
// Back end: key add or subtract, symbol encode and output register.
module vb64_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_decrypt,
    input  vb64_pkg::t_item         i_item,
    input  vb64_pkg::t_queue_status i_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_byte
);

    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic [5:0] w_sum;
    logic [7:0] w_byte;

    assign o_pop  = i_status.not_empty && (!r_valid || i_ready);
    assign w_sum  = i_decrypt ? (i_item.idx - i_item.key) : (i_item.idx + i_item.key);
    assign w_byte = i_item.ok ? vb64_pkg::encode_symbol(w_sum) : vb64_pkg::C_PAD;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte <= w_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule
